[rtl/stem_pkg.sv]
package stem_pkg;

	localparam int COUNT_BITS = 20;
	localparam int PHASE_BITS = 32;

	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 20;
	localparam int ALEN_W     = 16;
	localparam int STEP_W     = 17;
	localparam int AMP_W      = 15;
	localparam int PSTEP_W    = 31;
	localparam int CFG_DATA_W = 31;
	localparam int CFG_IDX_W  = 3;

	localparam int CMP_W   = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 1;
	localparam int PADD_W  = (PHASE_BITS > PSTEP_W) ? PHASE_BITS : PSTEP_W;
	localparam int PROD1_W = LEN_W + STEP_W;
	localparam int PROD2_W = STEP_W + AMP_W;
	localparam int ENV_FRAC = 16;
	localparam int MAG_W   = 16;
	localparam int ACC_W   = SAMPLE_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LENGTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LENGTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE      = 3'd6;

	localparam logic [STEP_W-1:0]   ENV_ONE       = 17'h10000;
	localparam logic [ALEN_W-1:0]   ATTACK_LEN_RST  = 16'd220;
	localparam logic [STEP_W-1:0]   ATTACK_STEP_RST = 17'd298;
	localparam logic [LEN_W-1:0]    RELEASE_LEN_RST = 20'd1;
	localparam logic [STEP_W-1:0]   RELEASE_STEP_RST = 17'h10000;

	localparam logic signed [ACC_W-1:0] ACC_MAX = 18'sd32767;
	localparam logic signed [ACC_W-1:0] ACC_MIN = -18'sd32767;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic finish;
	} stem_cmd_t;

	typedef struct packed {
		logic out_free;
	} stem_sts_t;

endpackage

[rtl/stem_if.sv]
interface stem_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [stem_pkg::SAMPLE_W-1:0] mix_sample;
	logic                                 start_req;

	modport source (output valid, output mix_sample, output start_req, input ready);
	modport sink   (input valid, input mix_sample, input start_req, output ready);
endinterface

interface stem_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [stem_pkg::SAMPLE_W-1:0] mixed_sample;
	logic                                 in_note;

	modport source (output valid, output mixed_sample, output in_note, input ready);
	modport sink   (input valid, input mixed_sample, input in_note, output ready);
endinterface

[rtl/stem_ctrl.sv]
module stem_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  stem_pkg::stem_sts_t sts,
	output stem_pkg::stem_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SUM
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_SUM;
				ST_SUM: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = in_valid && (state_q == ST_IDLE);
	assign cmd.mul1   = (state_q == ST_MUL1);
	assign cmd.mul2   = (state_q == ST_MUL2);
	assign cmd.finish = (state_q == ST_SUM) && sts.out_free;

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free) else $error("result written while output held");

	a_load_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready && cmd.mul1) else $error("request not held off after load");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul1, cmd.mul2, cmd.finish})) else $error("commands overlap");

endmodule

[rtl/stem_dp.sv]
module stem_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  stem_pkg::stem_cmd_t                  cmd,
	output stem_pkg::stem_sts_t                  sts,
	input  logic                                 cfg_we,
	input  logic [stem_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stem_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic signed [stem_pkg::SAMPLE_W-1:0] mix_sample,
	input  logic                                 start_req,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [stem_pkg::SAMPLE_W-1:0] mixed_sample,
	output logic                                 in_note
);

	logic [stem_pkg::PSTEP_W-1:0]    phase_step_q;
	logic [stem_pkg::LEN_W-1:0]      note_length_q;
	logic [stem_pkg::ALEN_W-1:0]     attack_length_q;
	logic [stem_pkg::STEP_W-1:0]     attack_step_q;
	logic [stem_pkg::LEN_W-1:0]      release_length_q;
	logic [stem_pkg::STEP_W-1:0]     release_step_q;
	logic [stem_pkg::AMP_W-1:0]      amplitude_q;

	logic [stem_pkg::COUNT_BITS-1:0] idx_q;
	logic [stem_pkg::PHASE_BITS-1:0] phase_q;

	logic signed [stem_pkg::SAMPLE_W-1:0] mix_q;
	logic                                 neg_q;
	logic                                 note_q;
	logic [stem_pkg::LEN_W-1:0]           opa_q;
	logic [stem_pkg::STEP_W-1:0]          opb_q;
	logic [stem_pkg::PROD1_W-1:0]         prod1_q;
	logic [stem_pkg::PROD2_W-1:0]         prod2_q;

	logic                                 out_valid_q;
	logic signed [stem_pkg::SAMPLE_W-1:0] mixed_q;
	logic                                 in_note_q;

	logic [stem_pkg::COUNT_BITS-1:0] i_now;
	logic [stem_pkg::CMP_W-1:0]      i_ext;
	logic [stem_pkg::CMP_W-1:0]      nl_ext;
	logic [stem_pkg::CMP_W-1:0]      rel_end;
	logic [stem_pkg::CMP_W-1:0]      remain;
	logic                            is_note;
	logic                            is_atk;
	logic                            is_rel;
	logic [stem_pkg::STEP_W-1:0]     env;
	logic [stem_pkg::MAG_W-1:0]      mag;
	logic signed [stem_pkg::ACC_W-1:0] mix_ext;
	logic signed [stem_pkg::ACC_W-1:0] mag_ext;
	logic signed [stem_pkg::ACC_W-1:0] acc;
	logic signed [stem_pkg::ACC_W-1:0] acc_sat;
	logic [stem_pkg::PADD_W-1:0]     phase_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q     <= '0;
			note_length_q    <= '0;
			attack_length_q  <= stem_pkg::ATTACK_LEN_RST;
			attack_step_q    <= stem_pkg::ATTACK_STEP_RST;
			release_length_q <= stem_pkg::RELEASE_LEN_RST;
			release_step_q   <= stem_pkg::RELEASE_STEP_RST;
			amplitude_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				stem_pkg::REG_PHASE_STEP:     phase_step_q <= cfg_data[stem_pkg::PSTEP_W-1:0];
				stem_pkg::REG_NOTE_LENGTH:    note_length_q <= cfg_data[stem_pkg::LEN_W-1:0];
				stem_pkg::REG_ATTACK_LENGTH:  attack_length_q <= cfg_data[stem_pkg::ALEN_W-1:0];
				stem_pkg::REG_ATTACK_STEP:    attack_step_q <= cfg_data[stem_pkg::STEP_W-1:0];
				stem_pkg::REG_RELEASE_LENGTH: release_length_q <= cfg_data[stem_pkg::LEN_W-1:0];
				stem_pkg::REG_RELEASE_STEP:   release_step_q <= cfg_data[stem_pkg::STEP_W-1:0];
				stem_pkg::REG_AMPLITUDE:      amplitude_q <= cfg_data[stem_pkg::AMP_W-1:0];
				default: ;
			endcase
		end
	end

	// classify the sample against the note, attack and release windows
	always_comb begin
		i_now   = start_req ? '0 : idx_q;
		i_ext   = stem_pkg::CMP_W'(i_now);
		nl_ext  = stem_pkg::CMP_W'(note_length_q);
		rel_end = i_ext + stem_pkg::CMP_W'(release_length_q);
		remain  = nl_ext - i_ext;
		is_note = i_ext < nl_ext;
		is_atk  = i_ext < stem_pkg::CMP_W'(attack_length_q);
		is_rel  = rel_end > nl_ext;
	end

	always_comb begin
		env = (prod1_q > stem_pkg::PROD1_W'(stem_pkg::ENV_ONE)) ? stem_pkg::ENV_ONE
			: prod1_q[stem_pkg::STEP_W-1:0];
		mag = prod2_q[stem_pkg::MAG_W+stem_pkg::ENV_FRAC-1:stem_pkg::ENV_FRAC];
		mix_ext = stem_pkg::ACC_W'(mix_q);
		mag_ext = $signed({2'b00, mag});
		acc     = neg_q ? (mix_ext - mag_ext) : (mix_ext + mag_ext);
		priority if (acc > stem_pkg::ACC_MAX) acc_sat = stem_pkg::ACC_MAX;
		else if (acc < stem_pkg::ACC_MIN)     acc_sat = stem_pkg::ACC_MIN;
		else                                  acc_sat = acc;
		phase_sum = stem_pkg::PADD_W'(phase_q) + stem_pkg::PADD_W'(phase_step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			phase_q <= '0;
		end else if (cmd.load && start_req) begin
			idx_q   <= '0;
			phase_q <= '0;
		end else if (cmd.finish && note_q) begin
			if (idx_q != '1) idx_q <= idx_q + 1'b1;
			phase_q <= phase_sum[stem_pkg::PHASE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mix_q  <= mix_sample;
			neg_q  <= start_req ? 1'b0 : phase_q[stem_pkg::PHASE_BITS-1];
			note_q <= is_note;
			if (is_atk) begin
				opa_q <= i_ext[stem_pkg::LEN_W-1:0];
				opb_q <= attack_step_q;
			end else if (is_rel) begin
				opa_q <= remain[stem_pkg::LEN_W-1:0];
				opb_q <= release_step_q;
			end else begin
				opa_q <= stem_pkg::LEN_W'(1);
				opb_q <= stem_pkg::ENV_ONE;
			end
		end
		if (cmd.mul1) prod1_q <= opa_q * opb_q;
		if (cmd.mul2) prod2_q <= env * amplitude_q;
		if (cmd.finish) begin
			mixed_q   <= note_q ? acc_sat[stem_pkg::SAMPLE_W-1:0] : mix_q;
			in_note_q <= note_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign mixed_sample  = mixed_q;
	assign in_note       = in_note_q;

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish)) else $error("result without finish");

	a_note_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && in_note_q) |-> (mixed_q != -16'sd32768))
		else $error("tone sum not saturated");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && start_req) |=> (idx_q == '0) && (phase_q == '0))
		else $error("start request did not clear note state");

endmodule

[rtl/square_tone_envelope_mixer.sv]
// A request is taken only in IDLE and passes through the MUL1, MUL2 and SUM states;
// the envelope and amplitude products are formed in MUL1 and MUL2. The result is
// registered on leaving SUM, and SUM waits while an earlier result is untaken.
// A waiting result does not block: the next request is taken while it is held.
// Reset (arst_n low, asynchronous) clears the sample index, phase, output valid
// and loads the register defaults.
module square_tone_envelope_mixer (
	input  logic                              clk,
	input  logic                              arst_n,
	stem_in_if.sink                           in_ch,
	stem_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [stem_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [stem_pkg::CFG_DATA_W-1:0]   cfg_data
);

	stem_pkg::stem_cmd_t cmd;
	stem_pkg::stem_sts_t sts;

	stem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stem_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mix_sample   (in_ch.mix_sample),
		.start_req    (in_ch.start_req),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.mixed_sample (out_ch.mixed_sample),
		.in_note      (out_ch.in_note)
	);

endmodule

[tb/square_tone_envelope_mixer_tb.sv]
`timescale 1ns / 1ps

module square_tone_envelope_mixer_tb;
	import stem_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 42;
	localparam int RANDOM_PHASES = 9;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic signed [SAMPLE_W-1:0] WALK_MIX [14] = '{16'sd0, 16'sd32767, 16'sh8000,
		16'sd0, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384, 16'sd32767, 16'sh8000, 16'sd100,
		-16'sd100, 16'sh8000, 16'sd32767};

	typedef struct {
		logic signed [SAMPLE_W-1:0] mixed_sample;
		logic                       in_note;
	} mix_result_t;

	class tone_scoreboard;
		logic [PSTEP_W-1:0]    pstep;
		logic [LEN_W-1:0]      note_len;
		logic [ALEN_W-1:0]     atk_len;
		logic [STEP_W-1:0]     atk_step;
		logic [LEN_W-1:0]      rel_len;
		logic [STEP_W-1:0]     rel_step;
		logic [AMP_W-1:0]      amp;
		logic [COUNT_BITS-1:0] sample_idx;
		logic [PHASE_BITS-1:0] phase;
		mix_result_t           mix_results[$];
		int                    fail_count;
		int                    note_samples;
		int                    clipped;

		function new();
			pstep        = '0;
			note_len     = '0;
			atk_len      = ATTACK_LEN_RST;
			atk_step     = ATTACK_STEP_RST;
			rel_len      = RELEASE_LEN_RST;
			rel_step     = RELEASE_STEP_RST;
			amp          = '0;
			sample_idx   = '0;
			phase        = '0;
			fail_count   = 0;
			note_samples = 0;
			clipped      = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PHASE_STEP:     pstep    = data[PSTEP_W-1:0];
				REG_NOTE_LENGTH:    note_len = data[LEN_W-1:0];
				REG_ATTACK_LENGTH:  atk_len  = data[ALEN_W-1:0];
				REG_ATTACK_STEP:    atk_step = data[STEP_W-1:0];
				REG_RELEASE_LENGTH: rel_len  = data[LEN_W-1:0];
				REG_RELEASE_STEP:   rel_step = data[STEP_W-1:0];
				REG_AMPLITUDE:      amp      = data[AMP_W-1:0];
				default: ;
			endcase
		endfunction

		function void add_request(logic signed [SAMPLE_W-1:0] mix, logic start);
			mix_result_t r;
			logic [63:0] env;
			logic [63:0] mag;
			int          v;
			if (start) begin
				sample_idx = '0;
				phase      = '0;
			end
			r.mixed_sample = mix;
			r.in_note      = 1'b0;
			if (64'(sample_idx) < 64'(note_len)) begin
				if (64'(sample_idx) < 64'(atk_len))
					env = 64'(sample_idx) * 64'(atk_step);
				else if (64'(sample_idx) + 64'(rel_len) > 64'(note_len))
					env = (64'(note_len) - 64'(sample_idx)) * 64'(rel_step);
				else
					env = 64'(ENV_ONE);
				if (env > 64'(ENV_ONE))
					env = 64'(ENV_ONE);
				mag = (env * 64'(amp)) >> ENV_FRAC;
				if (phase[PHASE_BITS-1])
					v = int'(mix) - int'(mag);
				else
					v = int'(mix) + int'(mag);
				if (v > int'(ACC_MAX)) begin
					v = int'(ACC_MAX);
					clipped++;
				end else if (v < int'(ACC_MIN)) begin
					v = int'(ACC_MIN);
					clipped++;
				end
				r.mixed_sample = SAMPLE_W'(v);
				r.in_note      = 1'b1;
				note_samples++;
				if (sample_idx != '1)
					sample_idx = sample_idx + 1'b1;
				phase = phase + PHASE_BITS'(pstep);
			end
			mix_results.push_back(r);
		endfunction

		function void check_mix(logic signed [SAMPLE_W-1:0] mixed, logic in_note);
			mix_result_t e;
			if (mix_results.size() == 0) begin
				$error("unexpected result: mixed_sample %0d, in_note %0b", mixed, in_note);
				fail_count++;
				return;
			end
			e = mix_results.pop_front();
			if (mixed !== e.mixed_sample) begin
				$error("mixed_sample: expected %0d, actual %0d", e.mixed_sample, mixed);
				fail_count++;
			end
			if (in_note !== e.in_note) begin
				$error("in_note: expected %0b, actual %0b", e.in_note, in_note);
				fail_count++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stem_in_if  in_ch();
	stem_out_if out_ch();

	tone_scoreboard sb;
	bit src_idle;
	bit sink_idle;
	bit hold_out;
	int requests_sent;
	int settings_used;

	always #1 clk = ~clk;

	square_tone_envelope_mixer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic logic signed [SAMPLE_W-1:0] random_mix();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
			input int w);
		logic [CFG_DATA_W-1:0] data;
		data = value;
		if (w < CFG_DATA_W && $urandom_range(0, 1) == 1)
			data = data | (CFG_DATA_W'($urandom) << w);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic load_tone(input logic [PSTEP_W-1:0] ps, input int nl, input int al,
			input int ast, input int rl, input int rst, input int am);
		write_reg(REG_PHASE_STEP, CFG_DATA_W'(ps), PSTEP_W);
		write_reg(REG_NOTE_LENGTH, CFG_DATA_W'(nl), LEN_W);
		write_reg(REG_ATTACK_LENGTH, CFG_DATA_W'(al), ALEN_W);
		write_reg(REG_ATTACK_STEP, CFG_DATA_W'(ast), STEP_W);
		write_reg(REG_RELEASE_LENGTH, CFG_DATA_W'(rl), LEN_W);
		write_reg(REG_RELEASE_STEP, CFG_DATA_W'(rst), STEP_W);
		write_reg(REG_AMPLITUDE, CFG_DATA_W'(am), AMP_W);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom), CFG_DATA_W);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_request(input logic signed [SAMPLE_W-1:0] mix, input logic start);
		int gap;
		gap = src_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.mix_sample <= mix;
		in_ch.start_req  <= start;
		do @(posedge clk); while (!in_ch.ready);
		sb.add_request(mix, start);
		requests_sent++;
	endtask

	task automatic settle();
		int w;
		w = 0;
		while (sb.mix_results.size() != 0 && w < DRAIN_LIMIT) begin
			@(posedge clk);
			w++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random_phase(input int n_items);
		int nl, al, ast, rl, rst, am;
		int done, run, cap;
		logic [PSTEP_W-1:0] ps;
		nl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1048575) : $urandom_range(1, 40);
		case ($urandom_range(0, 3))
			0: al = 0;
			1: al = $urandom_range(1, 65535);
			default: al = $urandom_range(1, ((nl < 20) ? nl : 20) + 1);
		endcase
		ast = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071) :
			((al > 0) ? 65536 / al : 65536);
		case ($urandom_range(0, 3))
			0: rl = 0;
			1: rl = $urandom_range(1, 1048575);
			default: rl = (nl / 5 > 1) ? nl / 5 : 1;
		endcase
		rst = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071) :
			((rl > 0) ? 65536 / rl : 65536);
		case ($urandom_range(0, 3))
			0: am = 0;
			1: am = 32767;
			default: am = $urandom_range(0, 32767);
		endcase
		ps = ($urandom_range(0, 1) == 1) ? PSTEP_W'($urandom) : PSTEP_W'($urandom_range(0, 1 << 28));
		load_tone(ps, nl, al, ast, rl, rst, am);
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(0, 6) == 0) begin
				send_request(random_mix(), 1'($urandom_range(0, 1)));
				done++;
			end else begin
				cap = (nl < 60) ? nl : 60;
				run = $urandom_range(1, cap + 4);
				if (run > n_items - done - 1)
					run = n_items - done - 1;
				send_request(random_mix(), 1'b1);
				done++;
				repeat (run) begin
					send_request(random_mix(), 1'b0);
					done++;
				end
			end
		end
		in_ch.valid <= 1'b0;
		settle();
	endtask

	initial begin
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int stall;
			if (hold_out) begin
				hold_out = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = sink_idle ? $urandom_range(0, 5) : 0;
				if (stall > 0) begin
					out_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			sb.check_mix(out_ch.mixed_sample, out_ch.in_note);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		int p;
		in_ch.valid      <= 1'b0;
		in_ch.mix_sample <= '0;
		in_ch.start_req  <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_PHASE_STEP;
		cfg_data         <= '0;
		arst_n           <= 1'b0;
		sb = new();
		src_idle      = 1'b0;
		sink_idle     = 1'b0;
		hold_out      = 1'b0;
		requests_sent = 0;
		settings_used = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: zero note length, pass through
		send_request(16'h7FFF, 1'b1);
		send_request(16'h8000, 1'b0);
		in_ch.valid <= 1'b0;
		settle();

		// one full note with attack, sustain, release and the tail after it
		load_tone(31'h40000000, 12, 3, 21845, 4, 16384, 32767);
		for (int k = 0; k < 14; k++)
			send_request(WALK_MIX[k], k == 0);
		in_ch.valid <= 1'b0;
		settle();

		// steep slopes held at full scale, no release
		load_tone(31'h7FFFFFFF, 1048575, 65535, 131071, 0, 131071, 32767);
		send_request(16'h8000, 1'b1);
		send_request(16'h7FFF, 1'b0);
		send_request(16'h8000, 1'b0);
		in_ch.valid <= 1'b0;
		settle();

		// no attack, release longer than the note
		load_tone(31'h55555555, 6, 0, 0, 1048575, 5000, 32767);
		send_request(16'sd12345, 1'b1);
		send_request(16'hFFFF, 1'b0);
		send_request(16'h7FFF, 1'b0);
		in_ch.valid <= 1'b0;
		settle();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			src_idle  = (p != 0) && ($urandom_range(0, 2) != 0);
			sink_idle = (p != 0) && ($urandom_range(0, 2) != 0);
			hold_out  = (p == 2);
			run_random_phase(PHASE_ITEMS);
		end

		if (sb.mix_results.size() != 0) begin
			$error("%0d expected results never arrived", sb.mix_results.size());
			sb.fail_count++;
		end
		$display("Sent %0d samples over %0d register settings, with one long output hold-off.",
			requests_sent, settings_used);
		$display("%0d samples fell inside a note, %0d of them clipped.",
			sb.note_samples, sb.clipped);
		if (sb.fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
rtl/stem_pkg.sv
rtl/stem_if.sv
rtl/stem_ctrl.sv
rtl/stem_dp.sv
rtl/square_tone_envelope_mixer.sv
tb/square_tone_envelope_mixer_tb.sv
